// ----- rtl/mrdq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package mrdq_pkg;

   // default sizes
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TAG_BITS    = 8;
   localparam int DEF_ROW_BITS    = 16;

   // opcodes
   localparam logic [2:0] OP_ADD     = 3'd0;
   localparam logic [2:0] OP_EXTRACT = 3'd1;
   localparam logic [2:0] OP_SELECT  = 3'd2;
   localparam logic [2:0] OP_COUNT   = 3'd3;
   localparam logic [2:0] OP_INFO    = 3'd4;

   // error codes
   localparam logic [1:0] ERR_OK    = 2'd0;
   localparam logic [1:0] ERR_RANGE = 2'd1;
   localparam logic [1:0] ERR_FULL  = 2'd2;

   // policy values
   localparam logic POLICY_OLDEST = 1'b0;
   localparam logic POLICY_FIFO   = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [7:0]  tag;
      logic        is_write;
      logic [15:0] row;
      logic [31:0] address;
      logic [8:0]  length;
      logic [63:0] timestamp;
      logic [3:0]  entry_index;
      logic        use_preferred;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  result_index;
      logic [7:0]  result_tag;
      logic [63:0] result_timestamp;
      logic        result_ready;
      logic [4:0]  result_count;
      logic [4:0]  occupancy_out;
      logic [1:0]  error_code;
   } rsp_type;

   // half-open byte ranges; an empty range overlaps nothing
   function automatic logic ranges_overlap(input logic [31:0] a0, input logic [8:0] l0,
                                           input logic [31:0] a1, input logic [8:0] l1);
      logic [32:0] end0;
      logic [32:0] end1;
      end0 = {1'b0, a0} + {24'd0, l0};
      end1 = {1'b0, a1} + {24'd0, l1};
      return (l0 != 9'd0) && (l1 != 9'd0) && ({1'b0, a0} < end1) && ({1'b0, a1} < end0);
   endfunction

endpackage
`default_nettype wire

// ----- rtl/mrdq_entry_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mrdq_entry_ram #(
   parameter int DEPTH  = 16,
   parameter int DATA_W = 8
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [DATA_W-1:0]        wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [DATA_W-1:0]        rdata
);

   logic [DATA_W-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata <= mem[raddr];
   end

endmodule
`default_nettype wire

// ----- rtl/mrdq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module mrdq_ctrl #(
   parameter int QUEUE_DEPTH = mrdq_pkg::DEF_QUEUE_DEPTH,
   parameter int TAG_BITS    = mrdq_pkg::DEF_TAG_BITS,
   parameter int ROW_BITS    = mrdq_pkg::DEF_ROW_BITS
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire mrdq_pkg::req_type req_data,
   output logic                   busy,
   input  wire logic              csr_we,
   input  wire logic              csr_wdata,
   output logic                   done_valid,
   output mrdq_pkg::rsp_type      done_data,
   input  wire logic              done_take
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_PRE  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   typedef struct packed {
      logic                wr;
      logic [ROW_BITS-1:0] row;
      logic [31:0]         addr;
      logic [8:0]          len;
      logic [63:0]         ts;
      logic                dep_valid;
      logic [TAG_BITS-1:0] dep_tag;
      logic [TAG_BITS-1:0] tag;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    occ_ff, occ_in;
   logic                policy_ff;
   mrdq_pkg::req_type   req_ff, req_in;
   logic [IDX_W-1:0]    ptr_ff, ptr_in;
   logic [CNT_W-1:0]    left_ff, left_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pos_ff, pos_in;
   logic                first_ff, first_in;
   logic [IDX_W-1:0]    fpos_ff, fpos_in;
   logic [TAG_BITS-1:0] ftag_ff, ftag_in;
   logic [63:0]         fts_ff, fts_in;
   logic [IDX_W-1:0]    sel_pos_ff, sel_pos_in;
   logic [TAG_BITS-1:0] sel_tag_ff, sel_tag_in;
   logic [63:0]         sel_ts_ff, sel_ts_in;
   logic                sel_ready_ff, sel_ready_in;
   logic [ROW_BITS-1:0] sel_row_ff, sel_row_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   mrdq_pkg::rsp_type   res_ff, res_in;

   logic                ram_we;
   logic [IDX_W-1:0]    ram_waddr;
   logic [IDX_W-1:0]    ram_raddr;
   logic [ENTRY_W-1:0]  ram_rdata;
   entry_type           wr_entry;
   entry_type           rd_entry;
   logic                acc;
   logic                idx_ok;
   logic                finish;
   logic                hit;
   logic                add_dep;
   logic [TAG_BITS-1:0] add_dep_tag;
   logic [ROW_BITS-1:0] q_row;
   logic [TAG_BITS-1:0] q_tag;
   logic                kind_ok;

   mrdq_entry_ram #(
      .DEPTH  (QUEUE_DEPTH),
      .DATA_W (ENTRY_W)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (wr_entry),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign rd_entry   = entry_type'(ram_rdata);
   assign busy       = (state_ff != S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_data  = res_ff;
   assign acc        = req_valid && !busy;
   assign idx_ok     = (32'(req_data.entry_index) < 32'(occ_ff));
   assign q_row      = ROW_BITS'(req_ff.row);
   assign q_tag      = TAG_BITS'(req_ff.tag);
   assign kind_ok    = (rd_entry.wr == req_ff.is_write) && !rd_entry.dep_valid;

   // sequence one operation over the entry memory
   always_comb begin
      state_in     = state_ff;
      occ_in       = occ_ff;
      req_in       = req_ff;
      ptr_in       = ptr_ff;
      left_in      = left_ff;
      pend_in      = 1'b0;
      pos_in       = pos_ff;
      first_in     = first_ff;
      fpos_in      = fpos_ff;
      ftag_in      = ftag_ff;
      fts_in       = fts_ff;
      sel_pos_in   = sel_pos_ff;
      sel_tag_in   = sel_tag_ff;
      sel_ts_in    = sel_ts_ff;
      sel_ready_in = sel_ready_ff;
      sel_row_in   = sel_row_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      ram_we       = 1'b0;
      ram_waddr    = pos_ff;
      ram_raddr    = ptr_ff;
      wr_entry     = rd_entry;
      finish       = 1'b0;
      hit          = 1'b0;
      add_dep      = 1'b0;
      add_dep_tag  = '0;

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               req_in   = req_data;
               res_in   = '0;
               first_in = 1'b0;
               cnt_in   = '0;
               ptr_in   = '0;
               res_in.occupancy_out = 5'(occ_ff);
               case (req_data.opcode)
                  mrdq_pkg::OP_ADD: begin
                     if (32'(occ_ff) >= QUEUE_DEPTH) begin
                        res_in.error_code = mrdq_pkg::ERR_FULL;
                        state_in = S_DONE;
                     end else begin
                        ptr_in   = IDX_W'(occ_ff - CNT_W'(1));
                        left_in  = occ_ff;
                        state_in = S_SCAN;
                     end
                  end
                  mrdq_pkg::OP_EXTRACT, mrdq_pkg::OP_INFO: begin
                     if (!idx_ok) begin
                        res_in.error_code = mrdq_pkg::ERR_RANGE;
                        state_in = S_DONE;
                     end else begin
                        ram_raddr  = IDX_W'(req_data.entry_index);
                        sel_pos_in = IDX_W'(req_data.entry_index);
                        state_in   = S_PRE;
                     end
                  end
                  mrdq_pkg::OP_SELECT: begin
                     if (policy_ff == mrdq_pkg::POLICY_FIFO) begin
                        left_in = (occ_ff != '0) ? CNT_W'(1) : '0;
                     end else begin
                        left_in = occ_ff;
                     end
                     state_in = S_SCAN;
                  end
                  mrdq_pkg::OP_COUNT: begin
                     left_in  = occ_ff;
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end

         S_PRE: begin
            // latch the addressed entry, then sweep the whole queue
            sel_tag_in   = rd_entry.tag;
            sel_ts_in    = rd_entry.ts;
            sel_ready_in = !rd_entry.dep_valid;
            sel_row_in   = rd_entry.row;
            ptr_in       = '0;
            if (req_ff.opcode == mrdq_pkg::OP_EXTRACT) begin
               left_in = occ_ff - CNT_W'(1);
            end else begin
               left_in = occ_ff;
            end
            state_in = S_SCAN;
         end

         S_SCAN: begin
            // issue the next read
            if (left_ff != '0) begin
               pend_in = 1'b1;
               pos_in  = ptr_ff;
               left_in = left_ff - CNT_W'(1);
               if (req_ff.opcode == mrdq_pkg::OP_ADD) begin
                  ptr_in = ptr_ff - IDX_W'(1);
               end else begin
                  ptr_in = ptr_ff + IDX_W'(1);
               end
               if ((req_ff.opcode == mrdq_pkg::OP_EXTRACT) && (ptr_ff >= sel_pos_ff)) begin
                  ram_raddr = ptr_ff + IDX_W'(1);
               end
            end

            // evaluate the returned entry
            if (pend_ff) begin
               case (req_ff.opcode)
                  mrdq_pkg::OP_ADD: begin
                     if (mrdq_pkg::ranges_overlap(req_ff.address, req_ff.length,
                                                  rd_entry.addr, rd_entry.len) &&
                         (req_ff.is_write || rd_entry.wr)) begin
                        add_dep     = 1'b1;
                        add_dep_tag = rd_entry.tag;
                        finish      = 1'b1;
                     end
                  end
                  mrdq_pkg::OP_EXTRACT: begin
                     ram_we    = 1'b1;
                     ram_waddr = pos_ff;
                     if (rd_entry.dep_valid && (rd_entry.dep_tag == sel_tag_ff)) begin
                        wr_entry.dep_valid = 1'b0;
                     end
                  end
                  mrdq_pkg::OP_SELECT: begin
                     if (kind_ok) begin
                        if (!first_ff) begin
                           first_in = 1'b1;
                           fpos_in  = pos_ff;
                           ftag_in  = rd_entry.tag;
                           fts_in   = rd_entry.ts;
                           if (!req_ff.use_preferred) begin
                              hit    = 1'b1;
                              finish = 1'b1;
                           end
                        end
                        if (rd_entry.row == q_row) begin
                           hit    = 1'b1;
                           finish = 1'b1;
                        end
                     end
                  end
                  mrdq_pkg::OP_COUNT: begin
                     if ((rd_entry.row == q_row) && (rd_entry.wr == req_ff.is_write)) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end else if (policy_ff == mrdq_pkg::POLICY_FIFO) begin
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     if (rd_entry.row == sel_row_ff) begin
                        cnt_in = cnt_ff + CNT_W'(1);
                     end
                  end
               endcase
            end

            if ((left_ff == '0) && !pend_ff) begin
               finish = 1'b1;
            end

            // close the operation
            if (finish) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
               case (req_ff.opcode)
                  mrdq_pkg::OP_ADD: begin
                     wr_entry.wr        = req_ff.is_write;
                     wr_entry.row       = q_row;
                     wr_entry.addr      = req_ff.address;
                     wr_entry.len       = req_ff.length;
                     wr_entry.ts        = req_ff.timestamp;
                     wr_entry.dep_valid = add_dep;
                     wr_entry.dep_tag   = add_dep_tag;
                     wr_entry.tag       = q_tag;
                     ram_we             = 1'b1;
                     ram_waddr          = IDX_W'(occ_ff);
                     occ_in             = occ_ff + CNT_W'(1);
                     res_in.found       = 1'b1;
                  end
                  mrdq_pkg::OP_EXTRACT: begin
                     occ_in                  = occ_ff - CNT_W'(1);
                     res_in.found            = 1'b1;
                     res_in.result_index     = 4'(sel_pos_ff);
                     res_in.result_tag       = 8'(sel_tag_ff);
                     res_in.result_timestamp = sel_ts_ff;
                     res_in.result_ready     = sel_ready_ff;
                  end
                  mrdq_pkg::OP_SELECT: begin
                     if (hit) begin
                        res_in.found            = 1'b1;
                        res_in.result_index     = 4'(pos_ff);
                        res_in.result_tag       = 8'(rd_entry.tag);
                        res_in.result_timestamp = rd_entry.ts;
                        res_in.result_ready     = 1'b1;
                     end else if (first_ff) begin
                        res_in.found            = 1'b1;
                        res_in.result_index     = 4'(fpos_ff);
                        res_in.result_tag       = 8'(ftag_ff);
                        res_in.result_timestamp = fts_ff;
                        res_in.result_ready     = 1'b1;
                     end
                  end
                  mrdq_pkg::OP_COUNT: begin
                     res_in.found        = 1'b1;
                     res_in.result_count = 5'(cnt_ff);
                  end
                  default: begin
                     res_in.found            = 1'b1;
                     res_in.result_index     = 4'(sel_pos_ff);
                     res_in.result_tag       = 8'(sel_tag_ff);
                     res_in.result_timestamp = sel_ts_ff;
                     res_in.result_ready     = sel_ready_ff;
                     res_in.result_count     = 5'(cnt_ff);
                  end
               endcase
               res_in.occupancy_out = 5'(occ_in);
            end
         end

         S_DONE: begin
            if (done_take) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         occ_ff    <= '0;
         policy_ff <= mrdq_pkg::POLICY_OLDEST;
         pend_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         pend_ff  <= pend_in;
         if (csr_we) begin
            policy_ff <= csr_wdata;
         end
      end
   end

   // operation payload
   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      ptr_ff       <= ptr_in;
      left_ff      <= left_in;
      pos_ff       <= pos_in;
      first_ff     <= first_in;
      fpos_ff      <= fpos_in;
      ftag_ff      <= ftag_in;
      fts_ff       <= fts_in;
      sel_pos_ff   <= sel_pos_in;
      sel_tag_ff   <= sel_tag_in;
      sel_ts_ff    <= sel_ts_in;
      sel_ready_ff <= sel_ready_in;
      sel_row_ff   <= sel_row_in;
      cnt_ff       <= cnt_in;
      res_ff       <= res_in;
   end

`ifndef NO_ASSERTIONS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= QUEUE_DEPTH)
      else $error("occupancy beyond queue depth");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_SCAN))
      else $error("entry memory written outside a scan");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      acc |=> (state_ff != S_IDLE))
      else $error("accepted transfer did not start an operation");

   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == S_SCAN))
      else $error("entry read returned outside a scan");
`endif

endmodule
`default_nettype wire

// ----- rtl/mem_request_dependency_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | transfer when         | payload
// req     | in        | req_valid & !req_stall | opcode, tag, is_write, row, address, length,
//         |           |                        | timestamp, entry_index, use_preferred
// rsp     | out       | rsp_valid & !rsp_stall | found, result_index, result_tag,
//         |           |                        | result_timestamp, result_ready, result_count,
//         |           |                        | occupancy_out, error_code
// csr     | in        | csr_we                 | csr_wdata (policy)
//
// One operation at a time. Add, select, count, extract and info scan the queue; add,
// select and count can stop the scan early, and rejected and unused opcodes skip it.
// The entry memory read port scans one entry per cycle.
// Synchronous active-high reset empties the queue and sets policy to oldest-ready-first.
// A finished result waits in the output register while the next transfer is accepted.
module mem_request_dependency_queue_core #(
   parameter int QUEUE_DEPTH = mrdq_pkg::DEF_QUEUE_DEPTH,
   parameter int TAG_BITS    = mrdq_pkg::DEF_TAG_BITS,
   parameter int ROW_BITS    = mrdq_pkg::DEF_ROW_BITS
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_opcode,
   input  wire logic [7:0]  req_tag,
   input  wire logic        req_is_write,
   input  wire logic [15:0] req_row,
   input  wire logic [31:0] req_address,
   input  wire logic [8:0]  req_length,
   input  wire logic [63:0] req_timestamp,
   input  wire logic [3:0]  req_entry_index,
   input  wire logic        req_use_preferred,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_found,
   output logic [3:0]       rsp_result_index,
   output logic [7:0]       rsp_result_tag,
   output logic [63:0]      rsp_result_timestamp,
   output logic             rsp_result_ready,
   output logic [4:0]       rsp_result_count,
   output logic [4:0]       rsp_occupancy_out,
   output logic [1:0]       rsp_error_code,
   input  wire logic        csr_we,
   input  wire logic        csr_wdata
);

   mrdq_pkg::req_type req_data;
   mrdq_pkg::rsp_type done_data;
   mrdq_pkg::rsp_type rsp_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              busy;
   logic              done_valid;
   logic              done_take;

   assign req_data.opcode        = req_opcode;
   assign req_data.tag           = req_tag;
   assign req_data.is_write      = req_is_write;
   assign req_data.row           = req_row;
   assign req_data.address       = req_address;
   assign req_data.length        = req_length;
   assign req_data.timestamp     = req_timestamp;
   assign req_data.entry_index   = req_entry_index;
   assign req_data.use_preferred = req_use_preferred;

   mrdq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TAG_BITS    (TAG_BITS),
      .ROW_BITS    (ROW_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .busy       (busy),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .done_valid (done_valid),
      .done_data  (done_data),
      .done_take  (done_take)
   );

   assign req_stall = busy;

   // load the output register when it is empty or draining
   assign done_take = done_valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done_take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done_take) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_found            = rsp_data_ff.found;
   assign rsp_result_index     = rsp_data_ff.result_index;
   assign rsp_result_tag       = rsp_data_ff.result_tag;
   assign rsp_result_timestamp = rsp_data_ff.result_timestamp;
   assign rsp_result_ready     = rsp_data_ff.result_ready;
   assign rsp_result_count     = rsp_data_ff.result_count;
   assign rsp_occupancy_out    = rsp_data_ff.occupancy_out;
   assign rsp_error_code       = rsp_data_ff.error_code;

endmodule
`default_nettype wire

// ----- sim/mem_request_dependency_queue_core_tb.sv -----
`timescale 1ns / 1ps
module mem_request_dependency_queue_core_tb;

   localparam int DEPTH = 16;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int N_RANDOM = 1950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_opcode = '0;
   logic [7:0] req_tag = '0;
   logic req_is_write = 1'b0;
   logic [15:0] req_row = '0;
   logic [31:0] req_address = '0;
   logic [8:0] req_length = '0;
   logic [63:0] req_timestamp = '0;
   logic [3:0] req_entry_index = '0;
   logic req_use_preferred = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_found;
   logic [3:0] rsp_result_index;
   logic [7:0] rsp_result_tag;
   logic [63:0] rsp_result_timestamp;
   logic rsp_result_ready;
   logic [4:0] rsp_result_count;
   logic [4:0] rsp_occupancy_out;
   logic [1:0] rsp_error_code;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;

   mem_request_dependency_queue_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_opcode(req_opcode), .req_tag(req_tag), .req_is_write(req_is_write),
      .req_row(req_row), .req_address(req_address), .req_length(req_length),
      .req_timestamp(req_timestamp), .req_entry_index(req_entry_index),
      .req_use_preferred(req_use_preferred),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_found(rsp_found), .rsp_result_index(rsp_result_index),
      .rsp_result_tag(rsp_result_tag), .rsp_result_timestamp(rsp_result_timestamp),
      .rsp_result_ready(rsp_result_ready), .rsp_result_count(rsp_result_count),
      .rsp_occupancy_out(rsp_occupancy_out), .rsp_error_code(rsp_error_code),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow queue of transactions
   typedef struct {
      logic [7:0]  tag;
      logic        wr;
      logic [15:0] row;
      logic [31:0] addr;
      logic [8:0]  len;
      logic [63:0] ts;
      logic        dep_v;
      logic [7:0]  dep_tag;
   } slot_type;

   slot_type shadow_q[DEPTH];
   int shadow_occ = 0;
   logic shadow_policy = mrdq_pkg::POLICY_OLDEST;
   mrdq_pkg::rsp_type pending_rsp[$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit timed_out = 1'b0;

   function automatic bit spans_meet(logic [31:0] a0, logic [8:0] l0,
                                     logic [31:0] a1, logic [8:0] l1);
      longint unsigned e0, e1;
      e0 = longint'(a0) + longint'(l0);
      e1 = longint'(a1) + longint'(l1);
      if (l0 == 0 || l1 == 0) return 1'b0;
      return (longint'(a0) < e1) && (longint'(a1) < e0);
   endfunction

   function automatic mrdq_pkg::rsp_type fill_entry(mrdq_pkg::rsp_type r, int p);
      r.result_index = p[3:0];
      r.result_tag = shadow_q[p].tag;
      r.result_timestamp = shadow_q[p].ts;
      r.result_ready = !shadow_q[p].dep_v;
      return r;
   endfunction

   // advance the shadow queue by one operation and return its response
   function automatic mrdq_pkg::rsp_type queue_apply(mrdq_pkg::req_type q);
      mrdq_pkg::rsp_type r;
      slot_type s;
      logic [7:0] gone;
      int i, fpos, pos, hits;
      bit first, hit;
      r = '0;
      case (q.opcode)
         mrdq_pkg::OP_ADD: begin
            if (shadow_occ >= DEPTH) begin
               r.error_code = mrdq_pkg::ERR_FULL;
            end else begin
               s.tag = q.tag; s.wr = q.is_write; s.row = q.row; s.addr = q.address;
               s.len = q.length; s.ts = q.timestamp; s.dep_v = 0; s.dep_tag = '0;
               for (i = shadow_occ - 1; i >= 0; i--) begin
                  if (spans_meet(q.address, q.length, shadow_q[i].addr, shadow_q[i].len) &&
                      (q.is_write || shadow_q[i].wr)) begin
                     s.dep_v = 1; s.dep_tag = shadow_q[i].tag;
                     break;
                  end
               end
               shadow_q[shadow_occ] = s;
               shadow_occ++;
               r.found = 1;
            end
         end
         mrdq_pkg::OP_EXTRACT: begin
            if (q.entry_index >= shadow_occ) begin
               r.error_code = mrdq_pkg::ERR_RANGE;
            end else begin
               r = fill_entry(r, q.entry_index);
               r.found = 1;
               gone = shadow_q[q.entry_index].tag;
               for (i = q.entry_index; i + 1 < shadow_occ; i++) shadow_q[i] = shadow_q[i + 1];
               shadow_occ--;
               for (i = 0; i < shadow_occ; i++)
                  if (shadow_q[i].dep_v && shadow_q[i].dep_tag == gone) shadow_q[i].dep_v = 0;
            end
         end
         mrdq_pkg::OP_SELECT: begin
            hit = 0; pos = 0; first = 0; fpos = 0;
            if (shadow_policy == mrdq_pkg::POLICY_OLDEST) begin
               for (i = 0; i < shadow_occ; i++) begin
                  if (shadow_q[i].wr == q.is_write && !shadow_q[i].dep_v) begin
                     if (!first) begin
                        first = 1; fpos = i;
                        if (!q.use_preferred) break;
                     end
                     if (shadow_q[i].row == q.row) begin
                        hit = 1; pos = i;
                        break;
                     end
                  end
               end
               if (!hit && first) begin
                  hit = 1; pos = fpos;
               end
            end else if (shadow_occ > 0 && shadow_q[0].wr == q.is_write &&
                         !shadow_q[0].dep_v) begin
               hit = 1;
            end
            if (hit) begin
               r.found = 1;
               r = fill_entry(r, pos);
            end
         end
         mrdq_pkg::OP_COUNT: begin
            hits = 0;
            for (i = 0; i < shadow_occ; i++) begin
               if (shadow_q[i].row == q.row && shadow_q[i].wr == q.is_write) hits++;
               else if (shadow_policy == mrdq_pkg::POLICY_FIFO) break;
            end
            r.found = 1;
            r.result_count = hits[4:0];
         end
         mrdq_pkg::OP_INFO: begin
            if (q.entry_index >= shadow_occ) begin
               r.error_code = mrdq_pkg::ERR_RANGE;
            end else begin
               hits = 0;
               for (i = 0; i < shadow_occ; i++)
                  if (shadow_q[i].row == shadow_q[q.entry_index].row) hits++;
               r.found = 1;
               r = fill_entry(r, q.entry_index);
               r.result_count = hits[4:0];
            end
         end
         default: ;
      endcase
      r.occupancy_out = shadow_occ[4:0];
      return r;
   endfunction

   // directed rows: check_fixed marks rows with a typed-in response
   typedef struct {
      mrdq_pkg::req_type req;
      bit                check_fixed;
      mrdq_pkg::rsp_type rsp;
   } row_type;

   row_type plan[$];
   int burst_left = 0;
   bit burst_idle = 0;

   function automatic void plan_row(row_type r);
      plan.insert(plan.size(), r);
   endfunction

   function automatic mrdq_pkg::req_type mk(logic [2:0] op, logic [7:0] tg, logic wr,
                                            logic [15:0] rw, logic [31:0] ad, logic [8:0] ln,
                                            logic [63:0] ts, logic [3:0] ix, logic pf);
      mrdq_pkg::req_type q;
      q.opcode = op; q.tag = tg; q.is_write = wr; q.row = rw; q.address = ad;
      q.length = ln; q.timestamp = ts; q.entry_index = ix; q.use_preferred = pf;
      return q;
   endfunction

   function automatic mrdq_pkg::rsp_type mkr(logic f, logic [4:0] occ, logic [1:0] err);
      mrdq_pkg::rsp_type r;
      r = '0; r.found = f; r.occupancy_out = occ; r.error_code = err;
      return r;
   endfunction

   // random transaction biased toward small, colliding windows
   function automatic mrdq_pkg::req_type random_req(int occ);
      mrdq_pkg::req_type q;
      int pick;
      q = '0;
      pick = $urandom_range(0, 99);
      if (pick < 40 && occ < DEPTH) q.opcode = mrdq_pkg::OP_ADD;
      else if (pick < 62) q.opcode = mrdq_pkg::OP_EXTRACT;
      else if (pick < 76) q.opcode = mrdq_pkg::OP_SELECT;
      else if (pick < 86) q.opcode = mrdq_pkg::OP_COUNT;
      else if (pick < 97) q.opcode = mrdq_pkg::OP_INFO;
      else q.opcode = 3'($urandom_range(0, 7));
      q.tag = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
      q.is_write = 1'($urandom);
      q.row = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
      q.address = ($urandom_range(0, 7) == 0) ? $urandom
                                               : 32'hFFFF_FC00 + $urandom_range(0, 1023);
      if ($urandom_range(0, 1)) q.address = $urandom_range(0, 1023);
      q.length = ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 256));
      if ($urandom_range(0, 31) == 0) q.length = 9'($urandom);
      q.timestamp = {$urandom, $urandom};
      q.entry_index = ($urandom_range(0, 4) == 0) ? 4'($urandom)
                                                    : 4'($urandom_range(0, occ > 0 ? occ - 1 : 0));
      q.use_preferred = 1'($urandom);
      return q;
   endfunction

   task automatic step_idle(output bit idle);
      if (quiet) begin
         idle = 0;
         return;
      end
      if (burst_left == 0) begin
         burst_idle = ($urandom_range(0, 3) == 0);
         burst_left = burst_idle ? $urandom_range(1, 6) : $urandom_range(1, 12);
      end
      burst_left--;
      idle = burst_idle;
   endtask

   // hold the payload until the transfer is taken; valid drops only on idle cycles
   task automatic send(mrdq_pkg::req_type q);
      bit idle;
      step_idle(idle);
      while (idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
         step_idle(idle);
      end
      req_valid <= 1'b1;
      {req_opcode, req_tag, req_is_write, req_row, req_address, req_length,
       req_timestamp, req_entry_index, req_use_preferred} <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic set_policy(logic p);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= p;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow_policy = p;
   endtask

   // receiver: random stalls and compare against the oldest expectation
   int stall_left = 0;
   bit stall_on = 0;
   mrdq_pkg::rsp_type got, want;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_found, rsp_result_index, rsp_result_tag, rsp_result_timestamp,
                   rsp_result_ready, rsp_result_count, rsp_occupancy_out, rsp_error_code};
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %h", got);
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp %p got %p", want, got);
               end
            end
         end
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else begin
            if (stall_left == 0) begin
               stall_on = ($urandom_range(0, 3) == 0);
               stall_left = stall_on ? $urandom_range(1, 6) : $urandom_range(1, 12);
            end
            stall_left--;
            rsp_stall <= stall_on;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("mem_request_dependency_queue_core_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic run_row(row_type r);
      mrdq_pkg::rsp_type p;
      p = queue_apply(r.req);
      if (r.check_fixed && p !== r.rsp) begin
         mismatches++;
         if (mismatches <= 10) $display("predictor disagrees with table: %p vs %p", p, r.rsp);
      end
      pending_rsp.insert(pending_rsp.size(), r.check_fixed ? r.rsp : p);
      send(r.req);
   endtask

   initial begin
      int i, n;
      row_type r;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty queue queries and rejections
      r.check_fixed = 1;
      r.req = mk(mrdq_pkg::OP_EXTRACT, 0, 0, 0, 0, 1, 0, 0, 0);
      r.rsp = mkr(0, 0, mrdq_pkg::ERR_RANGE); plan_row(r);
      r.req = mk(mrdq_pkg::OP_INFO, 0, 0, 0, 0, 1, 0, 4'hF, 0);
      r.rsp = mkr(0, 0, mrdq_pkg::ERR_RANGE); plan_row(r);
      r.req = mk(mrdq_pkg::OP_SELECT, 0, 1, 0, 0, 1, 0, 0, 1);
      r.rsp = mkr(0, 0, mrdq_pkg::ERR_OK); plan_row(r);
      r.req = mk(mrdq_pkg::OP_COUNT, 0, 0, 0, 0, 1, 0, 0, 0);
      r.rsp = mkr(1, 0, mrdq_pkg::ERR_OK); plan_row(r);
      r.req = mk(3'd7, 8'hFF, 1, 16'hFFFF, '1, 9'h1FF, '1, 4'hF, 1);
      r.rsp = mkr(0, 0, mrdq_pkg::ERR_OK); plan_row(r);
      r.check_fixed = 0;
      // extremes, zero length, overlapping write chain, duplicate tags
      r.req = mk(mrdq_pkg::OP_ADD, 8'hFF, 1, 16'hFFFF, 32'hFFFF_FF00, 9'd256, '1, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_ADD, 8'h00, 0, 16'h0000, 32'hFFFF_FFFF, 9'd1, '0, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_ADD, 8'h05, 0, 16'h0001, 32'hFFFF_FF10, 9'd0, 64'h1, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_ADD, 8'h05, 1, 16'h0001, 32'h0, 9'd16, 64'h2, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_ADD, 8'h06, 0, 16'h0001, 32'h8, 9'd4, 64'h3, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_ADD, 8'h07, 1, 16'h0001, 32'hA, 9'd1, 64'h4, 0, 0);
      plan_row(r);
      r.req = mk(mrdq_pkg::OP_SELECT, 0, 0, 16'h0001, 0, 1, 0, 0, 1); plan_row(r);
      r.req = mk(mrdq_pkg::OP_SELECT, 0, 1, 16'h0001, 0, 1, 0, 0, 0); plan_row(r);
      r.req = mk(mrdq_pkg::OP_COUNT, 0, 1, 16'h0001, 0, 1, 0, 0, 0); plan_row(r);
      r.req = mk(mrdq_pkg::OP_INFO, 0, 0, 0, 0, 1, 0, 4'd4, 0); plan_row(r);
      r.req = mk(mrdq_pkg::OP_EXTRACT, 0, 0, 0, 0, 1, 0, 4'd3, 0); plan_row(r);
      r.req = mk(mrdq_pkg::OP_INFO, 0, 0, 0, 0, 1, 0, 4'd3, 0); plan_row(r);
      r.req = mk(mrdq_pkg::OP_EXTRACT, 0, 0, 0, 0, 1, 0, 4'hF, 0); plan_row(r);
      foreach (plan[k]) run_row(plan[k]);

      // fill to full and try one more add
      while (shadow_occ < DEPTH) begin
         r.check_fixed = 0;
         r.req = mk(mrdq_pkg::OP_ADD, 8'($urandom), 1'($urandom), 16'($urandom_range(0, 2)),
                    $urandom, 9'($urandom_range(1, 256)), {$urandom, $urandom}, 0, 0);
         run_row(r);
      end
      r.check_fixed = 1;
      r.req = mk(mrdq_pkg::OP_ADD, 8'h11, 0, 0, 0, 1, 0, 0, 0);
      r.rsp = mkr(0, 5'd16, mrdq_pkg::ERR_FULL);
      run_row(r);

      // FIFO policy on a full queue
      set_policy(mrdq_pkg::POLICY_FIFO);
      r.check_fixed = 0;
      r.req = mk(mrdq_pkg::OP_SELECT, 0, 0, 0, 0, 1, 0, 0, 1); run_row(r);
      r.req = mk(mrdq_pkg::OP_COUNT, 0, 0, 0, 0, 1, 0, 0, 0); run_row(r);

      // random phases alternating policy
      n = 0;
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) set_policy(ph[0]);
         if (ph == 5) quiet = 1;
         for (i = 0; i < N_RANDOM / 6; i++) begin
            r.check_fixed = 0;
            r.req = random_req(shadow_occ);
            run_row(r);
            n++;
         end
      end

      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("mem_request_dependency_queue_core_tb OK");
      end else begin
         $display("mem_request_dependency_queue_core_tb NOT OK");
      end
      $finish;
   end
endmodule
